// ----- hw/rtl/mfbr_pkg.sv -----
// Shared constants, command/status types and state codes for the marker framed byte receiver.
package mfbr_pkg;

  localparam int FRAME_CAPACITY = 8;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 3;
  localparam int LEN_W  = 4;
  localparam int WR_W   = $clog2(FRAME_CAPACITY + 1);
  localparam int RD_W   = (FRAME_CAPACITY > 1) ? $clog2(FRAME_CAPACITY) : 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_OPEN_BYTE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_BYTE = 1'd1;

  localparam logic [BYTE_W-1:0] OPEN_BYTE_RESET  = 8'd60;
  localparam logic [BYTE_W-1:0] CLOSE_BYTE_RESET = 8'd62;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LISTEN = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic store;
    logic clear_rd;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic is_end;
    logic full;
    logic rd_last;
    logic out_free;
  } status_t;

endpackage

// ----- hw/rtl/mfbr_rx_if.sv -----
// Input channel carrying one received byte per beat.
interface mfbr_rx_if;
  logic                        valid;
  logic                        ready;
  logic [mfbr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- hw/rtl/mfbr_tx_if.sv -----
// Output channel carrying one frame byte per beat.
interface mfbr_tx_if;
  logic                        valid;
  logic                        ready;
  logic [mfbr_pkg::BYTE_W-1:0] data_byte;
  logic [mfbr_pkg::IDX_W-1:0]  byte_index;
  logic [mfbr_pkg::LEN_W-1:0]  message_length;
  logic                        last;

  modport source (output valid, output data_byte, output byte_index,
                  output message_length, output last, input ready);
  modport sink (input valid, input data_byte, input byte_index,
                input message_length, input last, output ready);
endinterface

// ----- hw/rtl/marker_framed_byte_receiver.sv -----
// Top level of the marker framed byte receiver.
//
//   channel  dir  beat payload                                      handshake
//   rx       in   rx_byte                                           valid/ready
//   frame    out  data_byte, byte_index, message_length, last       valid/ready
//   cfg      in   cfg_index, cfg_data                               cfg_write_en
//
// A byte is taken while idle or listening. An end marker starts a run of one
// result per stored byte (one result for an empty frame); the run loads a result
// from the frame store into the output register whenever the output is free.
// rx is held off during a run; the next byte is taken as soon as the last result
// is loaded, even while it still waits. Synchronous reset returns to idle with
// the default markers.
module marker_framed_byte_receiver (
  input  logic                            clk,
  input  logic                            rst,
  mfbr_rx_if.sink                         rx,
  mfbr_tx_if.source                       frame,
  input  logic                            cfg_write_en,
  input  logic [mfbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfbr_pkg::CFG_DATA_W-1:0] cfg_data
);

  mfbr_pkg::cmd_t    cmd;
  mfbr_pkg::status_t st;

  mfbr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx.valid),
    .rx_ready (rx.ready),
    .st       (st),
    .cmd      (cmd)
  );

  mfbr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rx_byte      (rx.rx_byte),
    .cmd          (cmd),
    .st           (st),
    .frame        (frame)
  );

endmodule

// ----- hw/rtl/mfbr_ctrl.sv -----
// Frame controller state machine: idle, listen and emit sequencing.
module mfbr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              rx_valid,
  output logic              rx_ready,
  input  mfbr_pkg::status_t st,
  output mfbr_pkg::cmd_t    cmd
);

  mfbr_pkg::state_t state;
  mfbr_pkg::state_t state_next;
  logic             accept;

  assign accept = rx_valid && rx_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    rx_ready   = 1'b0;
    unique case (state)
      mfbr_pkg::ST_IDLE: begin
        rx_ready = 1'b1;
        if (accept && st.is_start) begin
          cmd.clear_wr = 1'b1;
          state_next   = mfbr_pkg::ST_LISTEN;
        end
      end
      mfbr_pkg::ST_LISTEN: begin
        rx_ready = 1'b1;
        if (accept) begin
          priority if (st.is_start) begin
            cmd.clear_wr = 1'b1;
          end else if (st.is_end) begin
            cmd.clear_rd = 1'b1;
            state_next   = mfbr_pkg::ST_EMIT;
          end else if (st.full) begin
            cmd.clear_wr = 1'b1;
            state_next   = mfbr_pkg::ST_IDLE;
          end else begin
            cmd.store = 1'b1;
          end
        end
      end
      mfbr_pkg::ST_EMIT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          if (st.rd_last) begin
            cmd.clear_wr = 1'b1;
            state_next   = mfbr_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = mfbr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfbr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_emit_blocks_input: assert property (@(posedge clk) disable iff (rst)
    state == mfbr_pkg::ST_EMIT |-> !rx_ready)
    else $error("input taken during emit");

  a_emit_follows_end: assert property (@(posedge clk) disable iff (rst)
    (state == mfbr_pkg::ST_LISTEN && accept && !st.is_start && st.is_end)
      |=> state == mfbr_pkg::ST_EMIT)
    else $error("end marker did not start emit");

endmodule

// ----- hw/rtl/mfbr_datapath.sv -----
// Marker registers, frame store, index counters and output register.
module mfbr_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [mfbr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mfbr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [mfbr_pkg::BYTE_W-1:0]         rx_byte,
  input  mfbr_pkg::cmd_t                      cmd,
  output mfbr_pkg::status_t                   st,
  mfbr_tx_if.source                           frame
);

  logic [mfbr_pkg::BYTE_W-1:0] open_byte;
  logic [mfbr_pkg::BYTE_W-1:0] close_byte;
  logic [mfbr_pkg::BYTE_W-1:0] frame_store [mfbr_pkg::FRAME_CAPACITY];
  logic [mfbr_pkg::WR_W-1:0]   write_index;
  logic [mfbr_pkg::RD_W-1:0]   read_index;
  logic                        empty;
  logic                        out_valid;
  logic [mfbr_pkg::BYTE_W-1:0] data_byte;
  logic [mfbr_pkg::IDX_W-1:0]  byte_index;
  logic [mfbr_pkg::LEN_W-1:0]  message_length;
  logic                        last;

  assign empty       = (write_index == '0);
  assign st.is_start = (rx_byte == open_byte);
  assign st.is_end   = (rx_byte == close_byte);
  assign st.full     = (write_index == mfbr_pkg::WR_W'(mfbr_pkg::FRAME_CAPACITY));
  assign st.rd_last  = empty
                    || ((mfbr_pkg::WR_W'(read_index) + mfbr_pkg::WR_W'(1)) == write_index);
  assign st.out_free = !out_valid || frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_byte  <= mfbr_pkg::OPEN_BYTE_RESET;
      close_byte <= mfbr_pkg::CLOSE_BYTE_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        mfbr_pkg::REG_OPEN_BYTE:  open_byte  <= cfg_data;
        mfbr_pkg::REG_CLOSE_BYTE: close_byte <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      frame_store[write_index[mfbr_pkg::RD_W-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
    end else begin
      if (cmd.clear_wr) begin
        write_index <= '0;
      end else if (cmd.store) begin
        write_index <= write_index + mfbr_pkg::WR_W'(1);
      end
      if (cmd.clear_rd) begin
        read_index <= '0;
      end else if (cmd.load_out) begin
        read_index <= read_index + mfbr_pkg::RD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      data_byte      <= empty ? '0 : frame_store[read_index];
      byte_index     <= mfbr_pkg::IDX_W'(read_index);
      message_length <= mfbr_pkg::LEN_W'(write_index);
      last           <= st.rd_last;
    end
  end

  assign frame.valid          = out_valid;
  assign frame.data_byte      = data_byte;
  assign frame.byte_index     = byte_index;
  assign frame.message_length = message_length;
  assign frame.last           = last;

  a_wr_bounded: assert property (@(posedge clk) disable iff (rst)
    write_index <= mfbr_pkg::WR_W'(mfbr_pkg::FRAME_CAPACITY))
    else $error("write index past capacity");

  a_no_store_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> !st.full)
    else $error("store into full frame");

  a_read_in_frame: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && !empty) |-> (mfbr_pkg::WR_W'(read_index) < write_index))
    else $error("read beyond stored bytes");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> st.out_free)
    else $error("output overwritten before taken");

endmodule

// ----- bench/tb.sv -----
// Testbench for the marker framed byte receiver: random framed traffic against a frame rebuild.
`timescale 1ns / 100ps

module tb;

  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic [mfbr_pkg::BYTE_W-1:0] data_byte;
    logic [mfbr_pkg::IDX_W-1:0]  byte_index;
    logic [mfbr_pkg::LEN_W-1:0]  message_length;
    logic                        last;
  } frame_beat_t;

  class frame_rebuilder;
    logic [mfbr_pkg::BYTE_W-1:0] open_byte  = mfbr_pkg::OPEN_BYTE_RESET;
    logic [mfbr_pkg::BYTE_W-1:0] close_byte = mfbr_pkg::CLOSE_BYTE_RESET;
    bit                          listening  = 0;
    int unsigned                 fill       = 0;
    logic [mfbr_pkg::BYTE_W-1:0] store [mfbr_pkg::FRAME_CAPACITY];
    frame_beat_t                 due [$];
    int                          errors     = 0;

    function void write_reg(logic [mfbr_pkg::CFG_IDX_W-1:0] idx,
                            logic [mfbr_pkg::CFG_DATA_W-1:0] value);
      if (idx == mfbr_pkg::REG_OPEN_BYTE) begin
        open_byte = value;
      end else if (idx == mfbr_pkg::REG_CLOSE_BYTE) begin
        close_byte = value;
      end
    endfunction

    function void take_rx_byte(logic [mfbr_pkg::BYTE_W-1:0] b);
      frame_beat_t beat;
      if (!listening) begin
        if (b == open_byte) begin
          listening = 1;
          fill = 0;
        end
      end else if (b == open_byte) begin
        fill = 0;
      end else if (b == close_byte) begin
        listening = 0;
        if (fill == 0) begin
          beat = '{data_byte: '0, byte_index: '0, message_length: '0, last: 1'b1};
          due.push_back(beat);
        end
        for (int k = 0; k < fill; k++) begin
          beat.data_byte      = store[k];
          beat.byte_index     = k[mfbr_pkg::IDX_W-1:0];
          beat.message_length = fill[mfbr_pkg::LEN_W-1:0];
          beat.last           = (k + 1 == fill);
          due.push_back(beat);
        end
        fill = 0;
      end else if (fill >= mfbr_pkg::FRAME_CAPACITY) begin
        listening = 0;
        fill = 0;
      end else begin
        store[fill] = b;
        fill++;
      end
    endfunction

    function void check_beat(frame_beat_t got);
      frame_beat_t want;
      if (due.size() == 0) begin
        $error("frame beat with nothing due: data_byte %0d byte_index %0d length %0d last %0b",
               got.data_byte, got.byte_index, got.message_length, got.last);
        errors++;
        return;
      end
      want = due.pop_front();
      if (got.data_byte !== want.data_byte) begin
        $error("data_byte: expected %0d, got %0d", want.data_byte, got.data_byte);
        errors++;
      end
      if (got.byte_index !== want.byte_index) begin
        $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
        errors++;
      end
      if (got.message_length !== want.message_length) begin
        $error("message_length: expected %0d, got %0d", want.message_length,
               got.message_length);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic                            cfg_write_en;
  logic [mfbr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mfbr_pkg::CFG_DATA_W-1:0] cfg_data;

  mfbr_rx_if rx ();
  mfbr_tx_if frame ();

  frame_rebuilder rebuild = new();
  bit             calm = 0;
  int             bytes_sent = 0;
  int             idle_cycles = 0;

  marker_framed_byte_receiver dut (
    .clk          (clk),
    .rst          (rst),
    .rx           (rx),
    .frame        (frame),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [mfbr_pkg::BYTE_W-1:0] any_byte();
    return mfbr_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [mfbr_pkg::BYTE_W-1:0] b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
    bytes_sent++;
  endtask

  task automatic drain();
    rx.valid <= 1'b0;
    @(posedge clk);
    while (rebuild.due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_markers(input logic [mfbr_pkg::BYTE_W-1:0] s,
                             input logic [mfbr_pkg::BYTE_W-1:0] e);
    cfg_write_en <= 1'b1;
    cfg_index    <= mfbr_pkg::REG_OPEN_BYTE;
    cfg_data     <= s;
    @(posedge clk);
    cfg_index    <= mfbr_pkg::REG_CLOSE_BYTE;
    cfg_data     <= e;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    rebuild.write_reg(mfbr_pkg::REG_OPEN_BYTE, s);
    rebuild.write_reg(mfbr_pkg::REG_CLOSE_BYTE, e);
    @(posedge clk);
  endtask

  task automatic random_traffic(input int count);
    int stop_at;
    int len;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 9) < 3) begin
          repeat ($urandom_range(1, 2)) send_byte(any_byte());
        end
        send_byte(rebuild.open_byte);
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 4)) send_byte(any_byte());
          send_byte(rebuild.open_byte);
        end
        len = $urandom_range(0, mfbr_pkg::FRAME_CAPACITY + 1);
        repeat (len) send_byte(any_byte());
        send_byte(rebuild.close_byte);
      end else if ($urandom_range(0, 1) == 0) begin
        repeat ($urandom_range(1, 5)) send_byte(any_byte());
      end else begin
        send_byte(rebuild.open_byte);
        repeat ($urandom_range(1, mfbr_pkg::FRAME_CAPACITY + 2)) send_byte(any_byte());
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rx.valid && rx.ready) rebuild.take_rx_byte(rx.rx_byte);
  end

  always @(posedge clk) begin
    if (!rst && frame.valid && frame.ready) begin
      rebuild.check_beat('{data_byte: frame.data_byte, byte_index: frame.byte_index,
                           message_length: frame.message_length, last: frame.last});
    end
  end

  always @(posedge clk) begin
    if (rst || (rx.valid && rx.ready) || (frame.valid && frame.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    frame.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      int stall;
      stall = gap_len();
      if (stall > 0) begin
        frame.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      frame.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    forever begin
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(50, 200)) @(posedge clk);
    end
  end

  initial begin
    logic [mfbr_pkg::BYTE_W-1:0] opening [$];
    logic [mfbr_pkg::BYTE_W-1:0] s;
    logic [mfbr_pkg::BYTE_W-1:0] e;
    opening = {8'hFF, mfbr_pkg::CLOSE_BYTE_RESET,
               mfbr_pkg::OPEN_BYTE_RESET, mfbr_pkg::CLOSE_BYTE_RESET,
               mfbr_pkg::OPEN_BYTE_RESET, 8'h00, mfbr_pkg::OPEN_BYTE_RESET, 8'hFF, 8'h01,
               mfbr_pkg::CLOSE_BYTE_RESET,
               mfbr_pkg::OPEN_BYTE_RESET, 8'h00, 8'h80, 8'h7F, 8'hFF, 8'h01, 8'hFE, 8'h55,
               8'hAA, mfbr_pkg::CLOSE_BYTE_RESET};
    rst          <= 1'b1;
    rx.valid     <= 1'b0;
    rx.rx_byte   <= '0;
    cfg_write_en <= 1'b0;
    cfg_index    <= mfbr_pkg::REG_OPEN_BYTE;
    cfg_data     <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening[i]) send_byte(opening[i]);
    send_byte(mfbr_pkg::OPEN_BYTE_RESET);
    repeat (mfbr_pkg::FRAME_CAPACITY + 1) send_byte(any_byte());
    send_byte(mfbr_pkg::CLOSE_BYTE_RESET);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin s = 8'h00; e = 8'hFF; end
        1: begin s = 8'hFF; e = 8'h00; end
        2: begin s = 8'h5A; e = 8'h5A; end
        3: begin s = mfbr_pkg::OPEN_BYTE_RESET; e = mfbr_pkg::CLOSE_BYTE_RESET; end
        default: begin
          s = any_byte();
          e = any_byte();
        end
      endcase
      set_markers(s, e);
      random_traffic(42);
      drain();
    end

    repeat (20) @(posedge clk);
    if (rebuild.errors == 0 && rebuild.due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (rebuild.due.size() != 0) begin
        $error("%0d frame beats never arrived", rebuild.due.size());
      end
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
